FILE: src/ksd_pkg.sv
`timescale 1ns / 1ps

package ksd_pkg;

   // Matrix geometry and fixed field sizes
   localparam int KSD_ROWS       = 4;
   localparam int KSD_COLS       = 4;
   localparam int KSD_SNAP_BITS  = 16;
   localparam int KSD_CODE_W     = 8;
   localparam int KSD_MAP_W      = 64;
   localparam int KSD_COUNT_W    = 3;

   // Number of matching scans before a code is taken as stable
   localparam logic [KSD_COUNT_W-1:0] KSD_STABLE_REPEATS = 3'd5;
   localparam logic [KSD_CODE_W-1:0]  KSD_NO_KEY         = 8'd0;

   // Command codes
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Configuration register indexes
   localparam logic CSR_KEYMAP_LOW  = 1'b0;
   localparam logic CSR_KEYMAP_HIGH = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic [KSD_SNAP_BITS-1:0] matrix_bits;
   } ksd_req_type;

   typedef struct packed {
      logic [KSD_CODE_W-1:0] key_code;
      logic                  is_read;
   } ksd_rsp_type;

   // One transaction moving from the input stage into the result stage
   typedef struct packed {
      logic                  fire;
      logic                  is_read;
      logic [KSD_CODE_W-1:0] code;
   } ksd_step_type;

endpackage

FILE: src/ksd_find.sv
`timescale 1ns / 1ps

module ksd_find (
   input  logic [ksd_pkg::KSD_SNAP_BITS-1:0] matrix_bits,
   input  logic [ksd_pkg::KSD_MAP_W-1:0]     keymap_low,
   input  logic [ksd_pkg::KSD_MAP_W-1:0]     keymap_high,
   output logic [ksd_pkg::KSD_CODE_W-1:0]    code
);
   import ksd_pkg::*;

   logic [2*KSD_MAP_W-1:0] map_all;

   assign map_all = {keymap_high, keymap_low};

   // Walk in reverse priority so the first pressed key (column, then row) wins
   always_comb begin
      code = KSD_NO_KEY;
      for (int c = KSD_COLS - 1; c >= 0; c--) begin
         for (int r = KSD_ROWS - 1; r >= 0; r--) begin
            if ((r * KSD_COLS + c) < KSD_SNAP_BITS) begin
               if (matrix_bits[r * KSD_COLS + c]) begin
                  code = map_all[(r * KSD_COLS + c) * KSD_CODE_W +: KSD_CODE_W];
               end
            end
         end
      end
   end

endmodule

FILE: src/ksd_debounce.sv
`timescale 1ns / 1ps

module ksd_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  ksd_pkg::ksd_step_type         step,
   output logic [ksd_pkg::KSD_CODE_W-1:0] latched_code
);
   import ksd_pkg::*;

   logic [KSD_CODE_W-1:0]  previous_code_ff, previous_code_in;
   logic [KSD_COUNT_W-1:0] stable_count_ff,  stable_count_in;
   logic [KSD_CODE_W-1:0]  candidate_code_ff, candidate_code_in;
   logic [KSD_CODE_W-1:0]  latched_code_ff,  latched_code_in;
   logic [KSD_COUNT_W-1:0] count_next;

   assign latched_code = latched_code_ff;

   always_comb begin
      previous_code_in  = previous_code_ff;
      stable_count_in   = stable_count_ff;
      candidate_code_in = candidate_code_ff;
      latched_code_in   = latched_code_ff;
      count_next        = (step.code == previous_code_ff) ?
                          stable_count_ff + 3'd1 : '0;
      if (step.fire) begin
         if (step.is_read) begin
            latched_code_in = KSD_NO_KEY;
         end else begin
            previous_code_in = step.code;
            stable_count_in  = count_next;
            if (count_next == KSD_STABLE_REPEATS) begin
               // stable release after a stable key: record the press
               if (step.code == KSD_NO_KEY && candidate_code_ff != KSD_NO_KEY) begin
                  latched_code_in = candidate_code_ff;
               end
               candidate_code_in = step.code;
               stable_count_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_code_ff  <= KSD_NO_KEY;
         stable_count_ff   <= '0;
         candidate_code_ff <= KSD_NO_KEY;
         latched_code_ff   <= KSD_NO_KEY;
      end else begin
         previous_code_ff  <= previous_code_in;
         stable_count_ff   <= stable_count_in;
         candidate_code_ff <= candidate_code_in;
         latched_code_ff   <= latched_code_in;
      end
   end

endmodule

FILE: src/keypad_scan_debounce_unit.sv
`timescale 1ns / 1ps

// Debounced 4x4 key matrix scanner. Each input transaction is either a scan
// snapshot (one bit per key, set while pressed) or a read. A scan picks the
// first pressed key, trying columns in order and rows within a column, maps
// it through the 16-entry code table held in keymap_low/keymap_high (code 0
// means no key), and runs the debounce: a code seen on five further scans in
// a row becomes the candidate, and a stable "no key" after a nonzero
// candidate latches that candidate as a key press on release. A read returns
// the latched code (0 if none) and clears it. Every transaction yields exactly
// one result; scans return key_code 0 with is_read 0. Throughput is one
// transaction per clock while rsp_stall is low; each passes through the input
// register, then the result register, updating debounce state between them.
// The code table must be written via the csr_ port while idle (not enforced).

module keypad_scan_debounce_unit (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ksd_pkg::ksd_req_type          req_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ksd_pkg::ksd_rsp_type          rsp_data,
   // configuration writes
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ksd_pkg::KSD_MAP_W-1:0] csr_wdata
);
   import ksd_pkg::*;

   // code table registers
   logic [KSD_MAP_W-1:0] keymap_low_ff,  keymap_low_in;
   logic [KSD_MAP_W-1:0] keymap_high_ff, keymap_high_in;

   // input stage
   logic        in_valid_ff, in_valid_in;
   ksd_req_type in_data_ff,  in_data_in;

   // result stage
   logic        out_valid_ff, out_valid_in;
   ksd_rsp_type out_data_ff,  out_data_in;

   logic                  advance;
   logic [KSD_CODE_W-1:0] scan_code;
   logic [KSD_CODE_W-1:0] latched_code;
   ksd_step_type          step;

   // A transaction moves forward when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   ksd_find u_find (
      .matrix_bits (in_data_ff.matrix_bits),
      .keymap_low  (keymap_low_ff),
      .keymap_high (keymap_high_ff),
      .code        (scan_code)
   );

   always_comb begin
      step.fire    = advance;
      step.is_read = (in_data_ff.cmd == CMD_READ);
      step.code    = scan_code;
   end

   ksd_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .latched_code (latched_code)
   );

   always_comb begin
      keymap_low_in  = keymap_low_ff;
      keymap_high_in = keymap_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEYMAP_LOW:  keymap_low_in  = csr_wdata;
            CSR_KEYMAP_HIGH: keymap_high_in = csr_wdata;
            default:         keymap_low_in  = keymap_low_ff;
         endcase
      end
   end

   always_comb begin
      // input register: load whenever we are not holding off the sender
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end

      // result register
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         if (in_data_ff.cmd == CMD_READ) begin
            out_data_in.key_code = latched_code;
            out_data_in.is_read  = 1'b1;
         end else begin
            out_data_in.key_code = KSD_NO_KEY;
            out_data_in.is_read  = 1'b0;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keymap_low_ff  <= '0;
         keymap_high_ff <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         keymap_low_ff  <= keymap_low_in;
         keymap_high_ff <= keymap_high_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule
